// ----- hdl/rts_pkg.sv -----
package rts_pkg;

    localparam int MS_W = 16;
    localparam int OP_W = 2;

    typedef logic [MS_W-1:0] ms_t;
    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_ADD    = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;
    localparam opcode_t OP_TICK   = 2'd2;
    localparam opcode_t OP_NOP    = 2'd3;

endpackage

// ----- hdl/rts_entry_store.sv -----
module rts_entry_store import rts_pkg::*; #(
    parameter int LIST_DEPTH = 8,
    parameter int CODE_WIDTH = 8,
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic                       wr_bank,
    input  logic [IDX_W-1:0]           wr_idx,
    input  logic [CODE_WIDTH+MS_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic                       rd_bank,
    input  logic [IDX_W-1:0]           rd_idx,
    output logic [CODE_WIDTH+MS_W-1:0] rd_data
);

    localparam int AW    = $clog2(2 * LIST_DEPTH);
    localparam int ENT_W = CODE_WIDTH + MS_W;

    // two banks of LIST_DEPTH entries: one holds the live list, the other
    // receives the rebuilt list during a sweep
    logic [ENT_W-1:0] mem [0:2*LIST_DEPTH-1];
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign wr_addr = wr_bank ? AW'(wr_idx) + AW'(LIST_DEPTH) : AW'(wr_idx);
    assign rd_addr = rd_bank ? AW'(rd_idx) + AW'(LIST_DEPTH) : AW'(rd_idx);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/response_timeout_supervisor.sv -----
// Response timeout supervisor: holds up to LIST_DEPTH pending commands sorted
// by milliseconds left, soonest first. Opcode 0 adds (replacing any entry with
// the same code, rejected when full and no entry has it), 1 removes by code, 2
// ages every entry by s_elapsed_ms and retires at most one expired head entry,
// 3 only reports status. Each item produces exactly one result. The list lives
// in a two-bank memory with one read and one write port; add, remove and tick
// stream the live bank once, one entry per cycle, into the other bank and then
// swap banks, except for a rejected add. The sweep time grows with the number
// of pending entries, as the entry memory has a single read port. No new item
// is taken until the previous one is through, but a new item is taken while
// the previous result still waits on the m_ side.
module response_timeout_supervisor import rts_pkg::*; #(
    parameter int LIST_DEPTH = 8,
    parameter int CODE_WIDTH = 8,
    localparam int CNT_W = $clog2(LIST_DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_opcode,
    input  logic [CODE_WIDTH-1:0] s_cmd_code,
    input  logic [MS_W-1:0]       s_timeout_ms,
    input  logic [MS_W-1:0]       s_elapsed_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_expired,
    output logic [CODE_WIDTH-1:0] m_expired_code,
    output logic                  m_removed,
    output logic                  m_rejected_full,
    output logic [CNT_W-1:0]      m_entry_count,
    output logic [MS_W-1:0]       m_next_timeout_ms
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int ENT_W = CODE_WIDTH + MS_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  bank_reg, bank_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    ms_t                   head_ms_reg, head_ms_next;

    opcode_t               op_reg, op_next;
    logic [CODE_WIDTH-1:0] code_reg, code_next;
    ms_t                   tmo_reg, tmo_next;
    ms_t                   dt_reg, dt_next;

    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  proc_first_reg, proc_first_next;
    logic [CNT_W-1:0]      wr_idx_reg, wr_idx_next;
    logic                  hold_vld_reg, hold_vld_next;
    logic [ENT_W-1:0]      hold_reg, hold_next;
    logic                  inserted_reg, inserted_next;
    logic                  found_reg, found_next;
    logic                  exp_reg, exp_next;
    logic [CODE_WIDTH-1:0] exp_code_reg, exp_code_next;
    ms_t                   head_new_reg, head_new_next;

    logic                  res_expired_reg, res_expired_next;
    logic [CODE_WIDTH-1:0] res_code_reg, res_code_next;
    logic                  res_removed_reg, res_removed_next;
    logic                  res_rejected_reg, res_rejected_next;
    logic [CNT_W-1:0]      res_count_reg, res_count_next;
    ms_t                   res_head_reg, res_head_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_expired_reg, m_expired_next;
    logic [CODE_WIDTH-1:0] m_code_reg, m_code_next;
    logic                  m_removed_reg, m_removed_next;
    logic                  m_rejected_reg, m_rejected_next;
    logic [CNT_W-1:0]      m_count_reg, m_count_next;
    ms_t                   m_head_reg, m_head_next;

    logic                  rd_en;
    logic [ENT_W-1:0]      rd_data;
    logic                  wr_en;
    logic                  wr_fire;
    logic [ENT_W-1:0]      wr_entry;

    logic                  proc;
    logic                  fin;
    logic [CODE_WIDTH-1:0] e_code;
    ms_t                   e_ms;
    ms_t                   e_ms_aged;
    logic [ENT_W-1:0]      e_out;
    logic                  e_match;
    logic                  keep;
    logic                  insert_now;
    logic [ENT_W-1:0]      new_entry;
    logic [CNT_W-1:0]      count_new;
    ms_t                   head_new;
    logic                  reject;

    rts_entry_store #(
        .LIST_DEPTH (LIST_DEPTH),
        .CODE_WIDTH (CODE_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_bank (~bank_reg),
        .wr_idx  (wr_idx_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_bank (bank_reg),
        .rd_idx  (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_expired         = m_expired_reg;
    assign m_expired_code    = m_code_reg;
    assign m_removed         = m_removed_reg;
    assign m_rejected_full   = m_rejected_reg;
    assign m_entry_count     = m_count_reg;
    assign m_next_timeout_ms = m_head_reg;

    // per-entry merge: decide what the entry just read becomes
    assign proc       = (state_reg == S_SWEEP) && rd_pend_reg;
    assign fin        = (state_reg == S_SWEEP) && !rd_pend_reg && (rd_idx_reg == count_reg);
    assign e_code     = rd_data[ENT_W-1 -: CODE_WIDTH];
    assign e_ms       = rd_data[MS_W-1:0];
    assign e_ms_aged  = (op_reg == OP_TICK) ? ((e_ms > dt_reg) ? e_ms - dt_reg : '0) : e_ms;
    assign e_out      = {e_code, e_ms_aged};
    assign e_match    = (e_code == code_reg) && !found_reg;
    assign new_entry  = {code_reg, tmo_reg};

    always_comb begin
        keep = 1'b1;
        case (op_reg)
            OP_ADD, OP_REMOVE: keep = !e_match;
            OP_TICK:           keep = !(proc_first_reg && (e_ms_aged == '0));
            default:           keep = 1'b1;
        endcase
    end

    // new entry goes before the first surviving entry with more time left
    assign insert_now = (op_reg == OP_ADD) && !inserted_reg && keep && (e_ms > tmo_reg);
    assign wr_en      = wr_fire && (wr_idx_reg < DEPTH_C);

    always_comb begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        count_next      = count_reg;
        head_ms_next    = head_ms_reg;
        op_next         = op_reg;
        code_next       = code_reg;
        tmo_next        = tmo_reg;
        dt_next         = dt_reg;
        rd_idx_next     = rd_idx_reg;
        rd_pend_next    = 1'b0;
        proc_first_next = 1'b0;
        wr_idx_next     = wr_idx_reg;
        hold_vld_next   = hold_vld_reg;
        hold_next       = hold_reg;
        inserted_next   = inserted_reg;
        found_next      = found_reg;
        exp_next        = exp_reg;
        exp_code_next   = exp_code_reg;
        head_new_next   = head_new_reg;
        res_expired_next  = res_expired_reg;
        res_code_next     = res_code_reg;
        res_removed_next  = res_removed_reg;
        res_rejected_next = res_rejected_reg;
        res_count_next    = res_count_reg;
        res_head_next     = res_head_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_expired_next  = m_expired_reg;
        m_code_next     = m_code_reg;
        m_removed_next  = m_removed_reg;
        m_rejected_next = m_rejected_reg;
        m_count_next    = m_count_reg;
        m_head_next     = m_head_reg;
        rd_en           = 1'b0;
        wr_fire         = 1'b0;
        wr_entry        = hold_reg;
        count_new       = count_reg;
        head_new        = head_new_reg;
        reject          = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_opcode;
                    code_next     = s_cmd_code;
                    tmo_next      = s_timeout_ms;
                    dt_next       = s_elapsed_ms;
                    rd_idx_next   = '0;
                    wr_idx_next   = '0;
                    hold_vld_next = 1'b0;
                    inserted_next = 1'b0;
                    found_next    = 1'b0;
                    exp_next      = 1'b0;
                    exp_code_next = '0;
                    head_new_next = '0;
                    if (s_opcode == OP_NOP) begin
                        res_expired_next  = 1'b0;
                        res_code_next     = '0;
                        res_removed_next  = 1'b0;
                        res_rejected_next = 1'b0;
                        res_count_next    = count_reg;
                        res_head_next     = head_ms_reg;
                        state_next        = S_DONE;
                    end else begin
                        state_next = S_SWEEP;
                    end
                end
            end

            S_SWEEP: begin
                if (rd_idx_reg != count_reg) begin
                    rd_en           = 1'b1;
                    rd_idx_next     = rd_idx_reg + CNT_W'(1);
                    rd_pend_next    = 1'b1;
                    proc_first_next = (rd_idx_reg == '0);
                end

                if (proc) begin
                    if (e_match) begin
                        found_next = 1'b1;
                    end
                    if (!keep && (op_reg == OP_TICK)) begin
                        exp_next      = 1'b1;
                        exp_code_next = e_code;
                    end
                    // the hold stage delays the stream by one entry after an insert
                    if (hold_vld_reg) begin
                        wr_fire       = 1'b1;
                        wr_entry      = hold_reg;
                        hold_next     = e_out;
                        hold_vld_next = keep;
                    end else if (insert_now) begin
                        wr_fire       = 1'b1;
                        wr_entry      = new_entry;
                        hold_next     = e_out;
                        hold_vld_next = 1'b1;
                        inserted_next = 1'b1;
                    end else if (keep) begin
                        wr_fire  = 1'b1;
                        wr_entry = e_out;
                    end
                end else if (fin) begin
                    if (hold_vld_reg) begin
                        wr_fire       = 1'b1;
                        wr_entry      = hold_reg;
                        hold_vld_next = 1'b0;
                    end else if ((op_reg == OP_ADD) && !inserted_reg) begin
                        wr_fire       = 1'b1;
                        wr_entry      = new_entry;
                        inserted_next = 1'b1;
                    end
                end

                if (wr_fire) begin
                    wr_idx_next = wr_idx_reg + CNT_W'(1);
                    if (wr_idx_reg == '0) begin
                        head_new_next = wr_entry[MS_W-1:0];
                    end
                end
                count_new = wr_idx_reg + CNT_W'(wr_fire);
                head_new  = head_new_next;

                if (fin) begin
                    reject = (op_reg == OP_ADD) && (count_reg == DEPTH_C) && !found_reg;
                    res_expired_next  = exp_reg;
                    res_code_next     = exp_code_reg;
                    res_removed_next  = (op_reg == OP_REMOVE) && found_reg;
                    res_rejected_next = reject;
                    if (reject) begin
                        res_count_next = count_reg;
                        res_head_next  = head_ms_reg;
                    end else begin
                        bank_next      = ~bank_reg;
                        count_next     = count_new;
                        head_ms_next   = (count_new == '0) ? '0 : head_new;
                        res_count_next = count_new;
                        res_head_next  = (count_new == '0) ? '0 : head_new;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_expired_next  = res_expired_reg;
                    m_code_next     = res_code_reg;
                    m_removed_next  = res_removed_reg;
                    m_rejected_next = res_rejected_reg;
                    m_count_next    = res_count_reg;
                    m_head_next     = res_head_reg;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            bank_reg     <= 1'b0;
            count_reg    <= '0;
            head_ms_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            hold_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            count_reg    <= count_next;
            head_ms_reg  <= head_ms_next;
            rd_pend_reg  <= rd_pend_next;
            hold_vld_reg <= hold_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        code_reg         <= code_next;
        tmo_reg          <= tmo_next;
        dt_reg           <= dt_next;
        rd_idx_reg       <= rd_idx_next;
        proc_first_reg   <= proc_first_next;
        wr_idx_reg       <= wr_idx_next;
        hold_reg         <= hold_next;
        inserted_reg     <= inserted_next;
        found_reg        <= found_next;
        exp_reg          <= exp_next;
        exp_code_reg     <= exp_code_next;
        head_new_reg     <= head_new_next;
        res_expired_reg  <= res_expired_next;
        res_code_reg     <= res_code_next;
        res_removed_reg  <= res_removed_next;
        res_rejected_reg <= res_rejected_next;
        res_count_reg    <= res_count_next;
        res_head_reg     <= res_head_next;
        m_expired_reg    <= m_expired_next;
        m_code_reg       <= m_code_next;
        m_removed_reg    <= m_removed_next;
        m_rejected_reg   <= m_rejected_next;
        m_count_reg      <= m_count_next;
        m_head_reg       <= m_head_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("pending count above list depth");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rejected_full) |-> (m_entry_count == DEPTH_C) && !m_removed && !m_expired)
        else $error("reject reported on a list that is not full");

    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_entry_count == '0)) |-> (m_next_timeout_ms == '0))
        else $error("empty list reports a head timeout");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_SWEEP) |-> !wr_en && !rd_en)
        else $error("memory access outside a sweep");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken before the first finished");
`endif

endmodule
